// File: hdl/rc_stick_packet_builder_defines.svh
// Assertion macros for the stick packet builder checker.
// Included by any file that carries concurrent assertions; no other dependencies.
`ifndef RC_STICK_PACKET_BUILDER_DEFINES_SVH
`define RC_STICK_PACKET_BUILDER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define RCSPB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included
`define RCSPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rcspb_pkg.sv
// Shared types and constants for the stick packet builder.
// No dependencies; used by rc_stick_packet_builder.
package rcspb_pkg;

  // Channel and stick arithmetic
  localparam int CHAN_W     = 15;
  localparam int MAG_W      = 23;  // |channel| * gain fits in 23 bits
  localparam int STICK_W    = 10;  // clamped stick value 0..800
  localparam int STICK_GAIN = 400;
  localparam int STICK_MID  = 400;
  localparam int STICK_MAX  = 800;
  localparam int NUM_STICKS = 4;

  // Stick lanes
  localparam int STK_AIL = 0;
  localparam int STK_ELE = 1;
  localparam int STK_THR = 2;
  localparam int STK_RUD = 3;

  // One bit per lane: the lane uses a negative gain
  localparam logic [NUM_STICKS-1:0] GAIN_NEG = 4'b1011;

  // Frame geometry
  localparam int FRAME_LEN = 22;
  localparam int IDX_W     = 5;

  typedef logic [7:0] byte_t;

  // Fixed frame bytes
  localparam byte_t CHK_SEED     = 8'h6d;
  localparam byte_t HDR_1        = 8'h76;
  localparam byte_t HDR_2        = 8'h71;
  localparam byte_t HDR_3        = 8'h94;
  localparam byte_t FILL_BYTE    = 8'd100;
  localparam byte_t TRIM_CENTER  = 8'd64;
  localparam byte_t TRIM_OFS     = 8'd14;
  localparam byte_t STICK_PARK   = 8'd100;
  localparam byte_t THR_PARK     = 8'd0;
  localparam byte_t ZERO_BYTE    = 8'd0;

  // Flag bits of bytes 4 and 5
  localparam byte_t FLAG_BIND    = 8'h80;
  localparam byte_t FLAG_DATA    = 8'h04;
  localparam byte_t SW_FLIP      = 8'h08;
  localparam byte_t SW_PICTURE   = 8'h01;
  localparam byte_t SW_VIDEO     = 8'h02;
  localparam byte_t SW_LED       = 8'h80;
  localparam byte_t FLAG5_BASE   = 8'h06;
  localparam byte_t ARM_BIT      = 8'h40;
  localparam byte_t DISARM_BIT   = 8'h20;
  localparam byte_t TOG_BITS_RST = 8'h20;

  // Header bytes and stick override carried down the pipeline
  typedef struct packed {
    byte_t b4;
    byte_t b5;
    logic  forced;
  } hdr_t;

  // A switch channel is on when strictly positive
  function automatic logic is_positive(input logic [CHAN_W-1:0] v);
    return !v[CHAN_W-1] && (v != '0);
  endfunction

endpackage

// File: hdl/rc_stick_packet_builder.sv
// Stick packet builder top level: frame request in, 22 frame bytes out.
// Depends on rcspb_pkg.
//
//   channel | direction | payload                                  | handshake
//   --------+-----------+------------------------------------------+------------------
//   in      | input     | bind_mode, hop_toggle, nine channel values | in_valid/in_stall
//   out     | output    | byte_value, byte_index, last_byte        | out_valid/out_stall
//
// Each frame leaves the output one byte per cycle with no stall; the byte
// shift register at the output sets that rate. Frames follow each other with
// no gap when the next request is waiting. The accepting edge loads the scale
// stage; the request then moves to the quotient stage and then into the frame
// register. Two further requests wait in the two stages while a frame drains.
// Reset is synchronous and clears the pipeline and the arm state (disarmed,
// disarm flag set). A stall on the output holds the current byte and backs up
// into in_stall.
module rc_stick_packet_builder #(
  parameter int CHAN_FULL_SCALE = 10000
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   bind_mode,
  input  logic                                   hop_toggle,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    aileron_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    elevator_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    throttle_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    rudder_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    arm_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    led_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    flip_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    picture_in,
  input  logic signed [rcspb_pkg::CHAN_W-1:0]    video_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output rcspb_pkg::byte_t                       byte_value,
  output logic [rcspb_pkg::IDX_W-1:0]            byte_index,
  output logic                                   last_byte
);

  // Division by the full scale as an exact reciprocal multiply
  localparam int L_BITS = $clog2(CHAN_FULL_SCALE);
  localparam int KSH    = rcspb_pkg::MAG_W + L_BITS;
  localparam longint unsigned RECIP =
    ((longint'(1) << KSH) + CHAN_FULL_SCALE - 1) / CHAN_FULL_SCALE;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = rcspb_pkg::MAG_W + RW;
  localparam int QMAX   =
    ((1 << (rcspb_pkg::CHAN_W - 1)) * rcspb_pkg::STICK_GAIN) / CHAN_FULL_SCALE;
  localparam int QW     = $clog2(QMAX + 1);
  localparam int VW     = ((QW > rcspb_pkg::STICK_W) ? QW : rcspb_pkg::STICK_W) + 2;
  localparam int NS     = rcspb_pkg::NUM_STICKS;
  localparam int CW     = rcspb_pkg::CHAN_W;
  localparam int FL     = rcspb_pkg::FRAME_LEN;
  localparam int IW     = rcspb_pkg::IDX_W;
  localparam int SW     = rcspb_pkg::STICK_W;

  // Handshake
  logic in_fire, out_fire, frame_load, s1_ready, s2_ready, s1_move;

  // Arm state
  logic             is_armed;
  logic             arm_prev;
  rcspb_pkg::byte_t tog_bits;
  logic             arm_level;
  logic             arm_edge;
  rcspb_pkg::byte_t tog_bits_next;

  // Stage 1: header bytes and scaled magnitudes
  logic                           s1_valid;
  rcspb_pkg::hdr_t                s1_hdr;
  logic [rcspb_pkg::MAG_W-1:0]    s1_mag [NS];
  logic [NS-1:0]                  s1_neg;
  rcspb_pkg::hdr_t                hdr_next;
  logic [rcspb_pkg::MAG_W-1:0]    mag_next [NS];
  logic [NS-1:0]                  neg_next;
  logic [CW-1:0]                  stick_raw [NS];

  // Stage 2: quotients
  logic                           s2_valid;
  rcspb_pkg::hdr_t                s2_hdr;
  logic [QW-1:0]                  s2_q [NS];
  logic [NS-1:0]                  s2_neg;
  logic [QW-1:0]                  q_next [NS];

  // Output frame shift register
  rcspb_pkg::byte_t               frame_q [FL];
  rcspb_pkg::byte_t               frame_next [FL];
  logic [IW-1:0]                  idx;

  assign stick_raw[rcspb_pkg::STK_AIL] = aileron_in;
  assign stick_raw[rcspb_pkg::STK_ELE] = elevator_in;
  assign stick_raw[rcspb_pkg::STK_THR] = throttle_in;
  assign stick_raw[rcspb_pkg::STK_RUD] = rudder_in;

  // Pipeline flow
  assign out_fire   = out_valid && !out_stall;
  assign frame_load = s2_valid && (!out_valid || (out_fire && last_byte));
  assign s2_ready   = !s2_valid || frame_load;
  assign s1_move    = s1_valid && s2_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign in_stall   = !s1_ready;
  assign in_fire    = in_valid && !in_stall;

  // Arm edge detect and flag toggles
  always_comb begin
    arm_level     = rcspb_pkg::is_positive(arm_in);
    arm_edge      = arm_level != arm_prev;
    tog_bits_next = tog_bits;
    if (arm_edge) begin
      tog_bits_next = tog_bits ^ (arm_level ? rcspb_pkg::ARM_BIT : rcspb_pkg::DISARM_BIT);
    end
  end

  // Header bytes; sticks are parked from the arm state before this request
  always_comb begin
    hdr_next.forced = bind_mode || !is_armed;
    hdr_next.b4     = {1'b0, hop_toggle, 6'b0};
    hdr_next.b5     = rcspb_pkg::FLAG5_BASE | tog_bits_next;
    if (bind_mode) begin
      hdr_next.b4 = hdr_next.b4 | rcspb_pkg::FLAG_BIND;
    end else begin
      hdr_next.b4 = hdr_next.b4 | rcspb_pkg::FLAG_DATA
        | (rcspb_pkg::is_positive(flip_in)    ? rcspb_pkg::SW_FLIP    : rcspb_pkg::ZERO_BYTE)
        | (rcspb_pkg::is_positive(picture_in) ? rcspb_pkg::SW_PICTURE : rcspb_pkg::ZERO_BYTE)
        | (rcspb_pkg::is_positive(video_in)   ? rcspb_pkg::SW_VIDEO   : rcspb_pkg::ZERO_BYTE);
      hdr_next.b5 = hdr_next.b5
        | (rcspb_pkg::is_positive(led_in) ? rcspb_pkg::SW_LED : rcspb_pkg::ZERO_BYTE);
    end
  end

  // Magnitude of channel times gain, and the sign of the product
  always_comb begin
    logic [CW:0] ext;
    logic [CW:0] mag_abs;
    for (int i = 0; i < NS; i++) begin
      ext         = {stick_raw[i][CW-1], stick_raw[i]};
      mag_abs     = stick_raw[i][CW-1] ? (~ext + 1'b1) : ext;
      mag_next[i] = rcspb_pkg::MAG_W'(mag_abs[CW-1:0])
                    * rcspb_pkg::MAG_W'(rcspb_pkg::STICK_GAIN);
      neg_next[i] = stick_raw[i][CW-1] ^ rcspb_pkg::GAIN_NEG[i];
    end
  end

  // Quotient by reciprocal multiply, truncating the magnitude
  always_comb begin
    logic [PW-1:0] prod;
    logic [PW-1:0] shifted;
    for (int i = 0; i < NS; i++) begin
      prod      = PW'(s1_mag[i]) * PW'(RECIP);
      shifted   = prod >> KSH;
      q_next[i] = shifted[QW-1:0];
    end
  end

  // Assemble the frame from stage 2
  always_comb begin
    logic [VW-1:0]    v;
    logic [SW-1:0]    stick [NS];
    rcspb_pkg::byte_t hi [NS];
    rcspb_pkg::byte_t trim [NS];
    rcspb_pkg::byte_t chk;
    for (int i = 0; i < NS; i++) begin
      v = s2_neg[i] ? (VW'(rcspb_pkg::STICK_MID) - VW'(s2_q[i]))
                    : (VW'(rcspb_pkg::STICK_MID) + VW'(s2_q[i]));
      if (v[VW-1]) begin
        stick[i] = '0;
      end else if (v[VW-2:0] >= (VW-1)'(rcspb_pkg::STICK_MAX)) begin
        stick[i] = SW'(rcspb_pkg::STICK_MAX);
      end else begin
        stick[i] = v[SW-1:0];
      end
      hi[i]   = stick[i][SW-1:2];
      trim[i] = rcspb_pkg::byte_t'(stick[i][SW-1:3]) + rcspb_pkg::TRIM_OFS;
    end

    for (int i = 0; i < FL; i++) begin
      frame_next[i] = rcspb_pkg::ZERO_BYTE;
    end
    frame_next[1]  = rcspb_pkg::HDR_1;
    frame_next[2]  = rcspb_pkg::HDR_2;
    frame_next[3]  = rcspb_pkg::HDR_3;
    frame_next[4]  = s2_hdr.b4;
    frame_next[5]  = s2_hdr.b5;
    frame_next[6]  = s2_hdr.forced ? rcspb_pkg::STICK_PARK : hi[rcspb_pkg::STK_AIL];
    frame_next[7]  = s2_hdr.forced ? rcspb_pkg::STICK_PARK : hi[rcspb_pkg::STK_ELE];
    frame_next[8]  = s2_hdr.forced ? rcspb_pkg::THR_PARK   : hi[rcspb_pkg::STK_THR];
    frame_next[9]  = s2_hdr.forced ? rcspb_pkg::STICK_PARK : hi[rcspb_pkg::STK_RUD];
    frame_next[10] = rcspb_pkg::FILL_BYTE;
    frame_next[11] = rcspb_pkg::FILL_BYTE;
    frame_next[12] = rcspb_pkg::FILL_BYTE;
    frame_next[13] = rcspb_pkg::FILL_BYTE;
    frame_next[14] = {stick[rcspb_pkg::STK_AIL][1:0], stick[rcspb_pkg::STK_ELE][1:0],
                      stick[rcspb_pkg::STK_THR][1:0], stick[rcspb_pkg::STK_RUD][1:0]};
    frame_next[16] = trim[rcspb_pkg::STK_AIL];
    frame_next[17] = trim[rcspb_pkg::STK_ELE];
    frame_next[18] = rcspb_pkg::TRIM_CENTER;
    frame_next[19] = trim[rcspb_pkg::STK_RUD];

    // Checksum over bytes 1 to 21
    chk = rcspb_pkg::CHK_SEED;
    for (int i = 1; i < FL; i++) begin
      chk = chk ^ frame_next[i];
    end
    frame_next[0] = chk;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      is_armed  <= 1'b0;
      arm_prev  <= 1'b0;
      tog_bits  <= rcspb_pkg::TOG_BITS_RST;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (frame_load) begin
        out_valid <= 1'b1;
        idx       <= '0;
      end else if (out_fire) begin
        idx <= idx + 1'b1;
        if (last_byte) begin
          out_valid <= 1'b0;
        end
      end
      // Update the arm state in request order
      if (in_fire) begin
        tog_bits <= tog_bits_next;
        if (arm_edge) begin
          arm_prev <= arm_level;
          is_armed <= arm_level;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hdr <= hdr_next;
      s1_neg <= neg_next;
      for (int i = 0; i < NS; i++) begin
        s1_mag[i] <= mag_next[i];
      end
    end
    if (s1_move) begin
      s2_hdr <= s1_hdr;
      s2_neg <= s1_neg;
      for (int i = 0; i < NS; i++) begin
        s2_q[i] <= q_next[i];
      end
    end
    // Load a new frame or advance to the next byte
    if (frame_load) begin
      for (int i = 0; i < FL; i++) begin
        frame_q[i] <= frame_next[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < FL - 1; i++) begin
        frame_q[i] <= frame_q[i+1];
      end
    end
  end

  assign byte_value = frame_q[0];
  assign byte_index = idx;
  assign last_byte  = (idx == IW'(FL - 1));

endmodule

// File: hdl/rcspb_checker.sv
// Port-level checker for the stick packet builder, bound to the top level.
// Depends on rc_stick_packet_builder_defines.svh and rc_stick_packet_builder.
`include "rc_stick_packet_builder_defines.svh"

module rcspb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] byte_value,
  input logic [4:0] byte_index,
  input logic       last_byte
);

  // Hold a stalled output transaction
  `RCSPB_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(byte_value) && $stable(byte_index) && $stable(last_byte), "output changed under stall")

  // Advance the byte index by one within a frame
  `RCSPB_ASSERT(a_idx_step, clk, rst, out_valid && !out_stall && !last_byte |=> out_valid && (byte_index == $past(byte_index) + 5'd1), "byte index did not advance")

  // Flag the end of frame exactly on byte 21
  `RCSPB_ASSERT(a_last_pos, clk, rst, out_valid |-> (last_byte == (byte_index == 5'd21)), "last byte flag misplaced")

  // Start every following frame at byte 0
  `RCSPB_ASSERT(a_frame_start, clk, rst, out_valid && !out_stall && last_byte |=> !out_valid || (byte_index == 5'd0), "frame did not start at byte 0")

  // Drop all output and accept input right after reset
  `RCSPB_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind rc_stick_packet_builder rcspb_checker u_rcspb_checker (.*);

// File: test/rc_stick_packet_builder_tb.sv
// Self-checking testbench for rc_stick_packet_builder: directed and random frame
// requests, a frame predictor with its own arm state, and a byte-by-byte checker.
// Depends on rcspb_pkg and the rc_stick_packet_builder RTL.
module rc_stick_packet_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_FULL_SCALE = 10000;
  localparam int RANDOM_REQS     = 350;

  typedef logic signed [rcspb_pkg::CHAN_W-1:0] chan_t;

  typedef struct packed {
    logic  bind_mode;
    logic  hop_toggle;
    chan_t aileron;
    chan_t elevator;
    chan_t throttle;
    chan_t rudder;
    chan_t arm;
    chan_t led;
    chan_t flip;
    chan_t picture;
    chan_t video;
  } frame_req_t;

  typedef struct packed {
    rcspb_pkg::byte_t            value;
    logic [rcspb_pkg::IDX_W-1:0] index;
    logic                        last_flag;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic                        bind_mode   = 1'b0;
  logic                        hop_toggle  = 1'b0;
  chan_t                       aileron_in  = '0;
  chan_t                       elevator_in = '0;
  chan_t                       throttle_in = '0;
  chan_t                       rudder_in   = '0;
  chan_t                       arm_in      = '0;
  chan_t                       led_in      = '0;
  chan_t                       flip_in     = '0;
  chan_t                       picture_in  = '0;
  chan_t                       video_in    = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  rcspb_pkg::byte_t            byte_value;
  logic [rcspb_pkg::IDX_W-1:0] byte_index;
  logic                        last_byte;

  // Pending requests and the bytes they should produce
  frame_req_t  frame_req_q[$];
  frame_byte_t frame_bytes_q[$];

  // Predictor copy of the arm state
  logic             pred_armed;
  rcspb_pkg::byte_t pred_tog_bits;
  logic             pred_arm_prev;

  int error_count    = 0;
  int accepted_count = 0;
  int total_reqs     = 0;

  rc_stick_packet_builder #(
    .CHAN_FULL_SCALE(CHAN_FULL_SCALE)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .bind_mode   (bind_mode),
    .hop_toggle  (hop_toggle),
    .aileron_in  (aileron_in),
    .elevator_in (elevator_in),
    .throttle_in (throttle_in),
    .rudder_in   (rudder_in),
    .arm_in      (arm_in),
    .led_in      (led_in),
    .flip_in     (flip_in),
    .picture_in  (picture_in),
    .video_in    (video_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_value  (byte_value),
    .byte_index  (byte_index),
    .last_byte   (last_byte)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A switch or arm channel counts as on when strictly positive
  function automatic logic channel_on(input chan_t ch);
    return ch > 0;
  endfunction

  // Scale a stick channel, truncating toward zero, and clamp to the stick range
  function automatic logic [rcspb_pkg::STICK_W-1:0] scale_stick(input chan_t ch,
                                                                input int gain);
    int v;
    v = int'(ch) * gain / CHAN_FULL_SCALE + rcspb_pkg::STICK_MID;
    if (v < 0) v = 0;
    if (v > rcspb_pkg::STICK_MAX) v = rcspb_pkg::STICK_MAX;
    return v[rcspb_pkg::STICK_W-1:0];
  endfunction

  // Build the expected frame for one accepted request and queue its bytes
  task automatic predict_frame(input frame_req_t req);
    rcspb_pkg::byte_t              fr[rcspb_pkg::FRAME_LEN];
    logic [rcspb_pkg::STICK_W-1:0] ail, ele, thr, rud;
    logic                          forced, level;
    rcspb_pkg::byte_t              hop_bits, chk;
    frame_byte_t                   fb;
    int                            i;
    forced = req.bind_mode || !pred_armed;
    ail = scale_stick(req.aileron, -rcspb_pkg::STICK_GAIN);
    ele = scale_stick(req.elevator, -rcspb_pkg::STICK_GAIN);
    thr = scale_stick(req.throttle, rcspb_pkg::STICK_GAIN);
    rud = scale_stick(req.rudder, -rcspb_pkg::STICK_GAIN);
    level = channel_on(req.arm);

    // Toggle the arm or disarm flag on a level change, in any frame type
    if (level != pred_arm_prev) begin
      pred_arm_prev = level;
      if (level) begin
        pred_armed = 1'b1;
        pred_tog_bits ^= rcspb_pkg::ARM_BIT;
      end else begin
        pred_armed = 1'b0;
        pred_tog_bits ^= rcspb_pkg::DISARM_BIT;
      end
    end

    for (i = 0; i < rcspb_pkg::FRAME_LEN; i++) fr[i] = rcspb_pkg::ZERO_BYTE;
    fr[1] = rcspb_pkg::HDR_1;
    fr[2] = rcspb_pkg::HDR_2;
    fr[3] = rcspb_pkg::HDR_3;
    hop_bits = {1'b0, req.hop_toggle, 6'b0};
    if (req.bind_mode) begin
      fr[4] = hop_bits | rcspb_pkg::FLAG_BIND;
      fr[5] = rcspb_pkg::FLAG5_BASE | pred_tog_bits;
    end else begin
      fr[4] = hop_bits | rcspb_pkg::FLAG_DATA
            | (channel_on(req.flip)    ? rcspb_pkg::SW_FLIP    : rcspb_pkg::ZERO_BYTE)
            | (channel_on(req.picture) ? rcspb_pkg::SW_PICTURE : rcspb_pkg::ZERO_BYTE)
            | (channel_on(req.video)   ? rcspb_pkg::SW_VIDEO   : rcspb_pkg::ZERO_BYTE);
      fr[5] = rcspb_pkg::FLAG5_BASE | pred_tog_bits
            | (channel_on(req.led) ? rcspb_pkg::SW_LED : rcspb_pkg::ZERO_BYTE);
    end

    // Park the sticks while binding or disarmed
    fr[6]  = forced ? rcspb_pkg::STICK_PARK : ail[9:2];
    fr[7]  = forced ? rcspb_pkg::STICK_PARK : ele[9:2];
    fr[8]  = forced ? rcspb_pkg::THR_PARK   : thr[9:2];
    fr[9]  = forced ? rcspb_pkg::STICK_PARK : rud[9:2];
    fr[10] = rcspb_pkg::FILL_BYTE;
    fr[11] = rcspb_pkg::FILL_BYTE;
    fr[12] = rcspb_pkg::FILL_BYTE;
    fr[13] = rcspb_pkg::FILL_BYTE;
    fr[14] = {ail[1:0], ele[1:0], thr[1:0], rud[1:0]};
    fr[16] = rcspb_pkg::byte_t'(ail >> 3) + rcspb_pkg::TRIM_OFS;
    fr[17] = rcspb_pkg::byte_t'(ele >> 3) + rcspb_pkg::TRIM_OFS;
    fr[18] = rcspb_pkg::TRIM_CENTER;
    fr[19] = rcspb_pkg::byte_t'(rud >> 3) + rcspb_pkg::TRIM_OFS;

    chk = rcspb_pkg::CHK_SEED;
    for (i = 1; i < rcspb_pkg::FRAME_LEN; i++) chk ^= fr[i];
    fr[0] = chk;

    for (i = 0; i < rcspb_pkg::FRAME_LEN; i++) begin
      fb.value     = fr[i];
      fb.index     = rcspb_pkg::IDX_W'(i);
      fb.last_flag = (i == rcspb_pkg::FRAME_LEN - 1);
      frame_bytes_q.push_back(fb);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic frame_req_t make_req(input logic bm, input logic hop,
                                          input int ail, input int ele, input int thr,
                                          input int rud, input int arm, input int led,
                                          input int flip, input int pic, input int vid);
    frame_req_t req;
    req.bind_mode  = bm;
    req.hop_toggle = hop;
    req.aileron    = ail[rcspb_pkg::CHAN_W-1:0];
    req.elevator   = ele[rcspb_pkg::CHAN_W-1:0];
    req.throttle   = thr[rcspb_pkg::CHAN_W-1:0];
    req.rudder     = rud[rcspb_pkg::CHAN_W-1:0];
    req.arm        = arm[rcspb_pkg::CHAN_W-1:0];
    req.led        = led[rcspb_pkg::CHAN_W-1:0];
    req.flip       = flip[rcspb_pkg::CHAN_W-1:0];
    req.picture    = pic[rcspb_pkg::CHAN_W-1:0];
    req.video      = vid[rcspb_pkg::CHAN_W-1:0];
    return req;
  endfunction

  // Mostly in-range sticks, with full-range, corner and near-clamp values mixed in
  function automatic int rand_stick();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return int'($urandom_range(0, 20000)) - 10000;
    if (sel < 8) return int'($urandom_range(0, 32767)) - 16384;
    if (sel == 8) begin
      case ($urandom_range(0, 6))
        0:       return 0;
        1:       return 1;
        2:       return -1;
        3:       return CHAN_FULL_SCALE;
        4:       return -CHAN_FULL_SCALE;
        5:       return 16383;
        default: return -16384;
      endcase
    end
    return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(9900, 10100));
  endfunction

  // Switch channels: full 15-bit range with some zeros
  function automatic int rand_switch();
    if ($urandom_range(0, 7) == 0) return 0;
    return int'($urandom_range(0, 32767)) - 16384;
  endfunction

  // Fill the request queue, then wait for the drain and report
  initial begin : stimulus
    logic arm_high;
    int   arm_val;
    int   n;
    arm_high = 1'b0;

    // Disarmed after reset: sticks parked
    frame_req_q.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Arm edge in the same frame: still parked, arm flag toggles
    frame_req_q.push_back(make_req(0, 0, 16383, 16383, 16383, 16383, 16383,
                                   16383, 16383, 16383, 16383));
    // Armed: sticks past full scale clamp
    frame_req_q.push_back(make_req(0, 1, 16383, 16383, 16383, 16383, 16383,
                                   16383, 16383, 16383, 16383));
    frame_req_q.push_back(make_req(0, 0, -16384, -16384, -16384, -16384, 1,
                                   -16384, -16384, -16384, -16384));
    frame_req_q.push_back(make_req(0, 1, 10000, -10000, 10000, -10000, 1, 1, 1, 1, 1));
    // Truncation toward zero on negative products
    frame_req_q.push_back(make_req(0, 0, -26, 26, -26, 25, 1, -1, 0, -1, 0));
    frame_req_q.push_back(make_req(0, 0, -1, 1, -1, 1, 1, 16383, 0, -1, 16383));
    // Just inside and just past the clamp points
    frame_req_q.push_back(make_req(0, 1, -9975, 9999, 9975, -10025, 1, 0, 1, 0, 1));
    frame_req_q.push_back(make_req(0, 0, 10025, -9999, 10025, 9975, 1, 1, 0, 1, 0));
    // Alternating bit patterns
    frame_req_q.push_back(make_req(0, 1, 'h2aaa, 'h5555, 'h2aaa, 'h5555, 'h2aaa,
                                   'h5555, 'h2aaa, 'h5555, 'h2aaa));
    frame_req_q.push_back(make_req(0, 0, 'h5555, 'h2aaa, 'h5555, 'h2aaa, 'h2aaa,
                                   'h2aaa, 'h5555, 'h2aaa, 'h5555));
    // Bind while armed: sticks parked, switch flags dropped
    frame_req_q.push_back(make_req(1, 1, 3000, -3000, 5000, 700, 100,
                                   16383, 16383, 16383, 16383));
    // Disarm edge inside a bind frame
    frame_req_q.push_back(make_req(1, 0, 3000, -3000, 5000, 700, 0, 1, 1, 1, 1));
    // Disarmed data frame
    frame_req_q.push_back(make_req(0, 1, -4321, 1234, 8765, -555, -16384, 5, 5, 5, 5));
    // Arm edge inside a bind frame
    frame_req_q.push_back(make_req(1, 1, 0, 0, 0, 0, 5, 0, 0, 0, 0));
    frame_req_q.push_back(make_req(0, 1, 2500, 2500, -2500, -2500, 5, 9, 9, 9, 9));
    // Disarm edge in a data frame: sticks still live this frame
    frame_req_q.push_back(make_req(0, 0, 6000, -6000, 6000, -6000, -1, 0, 9, 0, 9));
    frame_req_q.push_back(make_req(0, 0, 6000, -6000, 6000, -6000, 0, 9, 0, 9, 0));
    // Re-arm toggles the arm flag back
    frame_req_q.push_back(make_req(0, 1, 1, 2, 3, 4, 16383, 0, 0, 0, 0));
    frame_req_q.push_back(make_req(0, 0, 400, -800, 1200, -1600, 16383, 1, 1, 1, 1));
    frame_req_q.push_back(make_req(1, 0, -16384, 16383, -16384, 16383, 0,
                                   16383, 16383, 16383, 16383));
    arm_high = 1'b0;

    // Random part: arm level held for runs, occasional bind frames and noise
    for (n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(0, 5) == 0) arm_high = !arm_high;
      if ($urandom_range(0, 19) == 0) arm_val = int'($urandom_range(0, 32767)) - 16384;
      else if (arm_high) arm_val = int'($urandom_range(1, 16383));
      else arm_val = ($urandom_range(0, 2) == 0) ? 0 : -int'($urandom_range(1, 16384));
      frame_req_q.push_back(make_req($urandom_range(0, 7) == 0, $urandom_range(0, 1),
                                     rand_stick(), rand_stick(), rand_stick(),
                                     rand_stick(), arm_val, rand_switch(), rand_switch(),
                                     rand_switch(), rand_switch()));
    end
    total_reqs = frame_req_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_reqs) @(posedge clk);
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Request driver: bursts of back-to-back transactions separated by random gaps
  frame_req_t drv_req;
  logic       drv_fire;
  logic       drv_valid_next;
  int         drv_burst_left = 1;
  int         drv_gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      // Reset the predictor arm state along with the block
      pred_armed    = 1'b0;
      pred_tog_bits = rcspb_pkg::TOG_BITS_RST;
      pred_arm_prev = 1'b0;
    end else begin
      drv_fire = in_valid && !in_stall;
      if (drv_fire) begin
        predict_frame(drv_req);
        accepted_count++;
        if (drv_burst_left <= 1) begin
          drv_burst_left = $urandom_range(1, 10);
          drv_gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
        end else begin
          drv_burst_left--;
        end
      end

      // Hold a stalled payload, otherwise idle out the gap or present the next one
      if (in_valid && !drv_fire) begin
        drv_valid_next = 1'b1;
      end else if (drv_gap_left > 0) begin
        drv_gap_left--;
        drv_valid_next = 1'b0;
      end else if (frame_req_q.size() > 0) begin
        drv_req = frame_req_q.pop_front();
        bind_mode   <= drv_req.bind_mode;
        hop_toggle  <= drv_req.hop_toggle;
        aileron_in  <= drv_req.aileron;
        elevator_in <= drv_req.elevator;
        throttle_in <= drv_req.throttle;
        rudder_in   <= drv_req.rudder;
        arm_in      <= drv_req.arm;
        led_in      <= drv_req.led;
        flip_in     <= drv_req.flip;
        picture_in  <= drv_req.picture;
        video_in    <= drv_req.video;
        drv_valid_next = 1'b1;
      end else begin
        drv_valid_next = 1'b0;
      end
      in_valid <= drv_valid_next;
    end
  end

  // Output stall pattern: rotating modes plus two long hold-offs that back up the input
  int   stall_cycle   = 0;
  int   stall_mode    = 0;
  int   holdoff_left  = 0;
  logic stall_next;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
      if (stall_cycle == 1000 || stall_cycle == 5000) holdoff_left = 300;
      if (holdoff_left > 0) begin
        holdoff_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ((stall_cycle % 5) < 2);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // Byte checker: compare each output transaction with the oldest expected byte
  frame_byte_t mon_want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch("byte with nothing expected, value", byte_value, -1);
      end else begin
        mon_want = frame_bytes_q.pop_front();
        if (byte_index !== mon_want.index)
          report_mismatch("byte_index", byte_index, mon_want.index);
        if (byte_value !== mon_want.value)
          report_mismatch($sformatf("byte_value at index %0d", mon_want.index),
                          byte_value, mon_want.value);
        if (last_byte !== mon_want.last_flag)
          report_mismatch($sformatf("last_byte at index %0d", mon_want.index),
                          last_byte, mon_want.last_flag);
      end
    end
  end

endmodule
